@@ sv/tss_pkg.sv @@
// Shared types and constants for the triangular system solver.
// No dependencies; imported by every module of the block.
package tss_pkg;

  localparam int MaxOrder  = 64;
  localparam int IdxW      = $clog2(MaxOrder);
  localparam int OrdW      = IdxW + 1;
  localparam int DataW     = 32;
  localparam int FracBits  = 16;
  localparam int AddrW     = 2 * IdxW;
  localparam int ProdW     = 2 * DataW;
  localparam int NumW      = DataW + FracBits;
  localparam int DivCntW   = $clog2(NumW);

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  // item actions
  localparam logic [1:0] ACT_LOAD_MAT = 2'd0;
  localparam logic [1:0] ACT_LOAD_RHS = 2'd1;
  localparam logic [1:0] ACT_SOLVE    = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] solution;
    logic                    last;
    logic                    status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_RD, S_MUL, S_ACC, S_PRD, S_PIV, S_DIV, S_WR,
    S_ORD, S_OLD, S_OWAIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic            wr_mat;
    logic            wr_rhs;
    logic            clr_sum;
    logic            rd_mac;
    logic            do_mul;
    logic            do_acc;
    logic            rd_piv;
    logic            ld_piv;
    logic            div_step;
    logic            wr_sol;
    logic            rd_out;
    logic            ld_out;
    logic            last;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic piv_zero;
  } stat_t;

endpackage

@@ sv/triangular_system_solver.sv @@
// Triangular system solver top level: sequencer plus datapath.
// Depends on tss_pkg, tss_ctrl and tss_datapath.
// Load beats (matrix or rhs entry) are taken one per cycle while idle. A
// solve beat stalls the input until all n solution beats are delivered.
// Each row takes row setup, then a store read, multiply and accumulate per
// off-diagonal term, then pivot fetch, the bit-serial divider (no steps on a
// zero pivot) and write-back; each output beat takes a store read, a result
// load and any output stall. Row i of forward substitution has i terms, of
// back substitution n-1-i terms.
module triangular_system_solver import tss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  item_t           item,
  output logic            result_valid,
  input  logic            result_stall,
  output result_t         result,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [OrdW-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_action  (item.action),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .cmd          (cmd)
  );

  tss_datapath u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

  // no input taken while a result beat is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open while result pending");

  // a zero pivot always yields a zero element
  a_zero_pivot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |-> (result.solution == '0))
    else $error("zero pivot with nonzero solution");

  // the last beat ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.last) |=> !result_valid)
    else $error("result after last beat");

endmodule

@@ sv/tss_ctrl.sv @@
// Solver sequencer: configuration registers, loop counters and the FSM.
// Depends on tss_pkg; drives tss_datapath through cmd_t.
module tss_ctrl import tss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_action,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [OrdW-1:0]  cfg_data,
  input  stat_t            stat,
  output cmd_t             cmd
);

  state_t              state, state_next;
  logic                mode;
  logic [OrdW-1:0]     n;
  logic [OrdW-1:0]     k, k_next;
  logic [OrdW-1:0]     j, j_next;
  logic [OrdW-1:0]     jend, jend_next;
  logic [DivCntW-1:0]  dcnt, dcnt_next;
  logic [OrdW-1:0]     i_full;
  logic [IdxW-1:0]     i;
  logic                fire_in;

  assign fire_in    = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign i_full     = mode ? (n - OrdW'(1) - k) : k;
  assign i          = i_full[IdxW-1:0];

  // configuration registers, order clamped to 1..MaxOrder
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      n    <= OrdW'(MaxOrder);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode <= cfg_data[0];
        CFG_SIZE: begin
          if (cfg_data == '0) n <= OrdW'(1);
          else if (cfg_data > OrdW'(MaxOrder)) n <= OrdW'(MaxOrder);
          else n <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      j     <= '0;
      jend  <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      jend  <= jend_next;
      dcnt  <= dcnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    k_next       = k;
    j_next       = j;
    jend_next    = jend;
    dcnt_next    = dcnt;
    cmd          = '0;
    cmd.row      = i;
    cmd.col      = j[IdxW-1:0];
    result_valid = 1'b0;
    case (state)
      S_IDLE: begin
        if (fire_in) begin
          case (item_action)
            ACT_LOAD_MAT: cmd.wr_mat = 1'b1;
            ACT_LOAD_RHS: cmd.wr_rhs = 1'b1;
            ACT_SOLVE: begin
              k_next     = '0;
              state_next = S_ROW;
            end
            default: ;
          endcase
        end
      end
      // set inner range for row i
      S_ROW: begin
        cmd.clr_sum = 1'b1;
        j_next      = mode ? i_full + OrdW'(1) : '0;
        jend_next   = mode ? n : i_full;
        state_next  = S_RD;
      end
      S_RD: begin
        if (j == jend) begin
          state_next = S_PRD;
        end else begin
          cmd.rd_mac = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        j_next     = j + OrdW'(1);
        state_next = S_RD;
      end
      // fetch pivot and rhs
      S_PRD: begin
        cmd.rd_piv = 1'b1;
        cmd.col    = i;
        state_next = S_PIV;
      end
      S_PIV: begin
        cmd.ld_piv = 1'b1;
        dcnt_next  = '0;
        state_next = S_DIV;
      end
      // one quotient bit per cycle
      S_DIV: begin
        if (stat.piv_zero) begin
          state_next = S_WR;
        end else begin
          cmd.div_step = 1'b1;
          dcnt_next    = dcnt + DivCntW'(1);
          if (dcnt == DivCntW'(NumW - 1)) state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_sol = 1'b1;
        if (k + OrdW'(1) == n) begin
          k_next     = '0;
          state_next = S_ORD;
        end else begin
          k_next     = k + OrdW'(1);
          state_next = S_ROW;
        end
      end
      // stream solution out in index order
      S_ORD: begin
        cmd.rd_out = 1'b1;
        cmd.row    = k[IdxW-1:0];
        state_next = S_OLD;
      end
      S_OLD: begin
        cmd.ld_out = 1'b1;
        cmd.row    = k[IdxW-1:0];
        cmd.last   = (k == n - OrdW'(1));
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          if (k == n - OrdW'(1)) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + OrdW'(1);
            state_next = S_ORD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/tss_datapath.sv @@
// Solver datapath: matrix, rhs and solution stores, multiply-accumulate,
// bit-serial divider and the result register. Depends on tss_pkg.
module tss_datapath import tss_pkg::*; (
  input  logic    clk,
  input  item_t   item,
  input  cmd_t    cmd,
  output stat_t   stat,
  output result_t result
);

  logic [DataW-1:0]        mat_mem [MaxOrder*MaxOrder];
  logic [DataW-1:0]        rhs_mem [MaxOrder];
  logic [DataW-1:0]        sol_mem [MaxOrder];
  logic [MaxOrder-1:0]     zp_bits;
  logic [DataW-1:0]        mat_q, rhs_q, sol_q;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] rnd;
  logic signed [ProdW-1:0] sum;
  logic signed [ProdW-1:0] dfull;
  logic signed [DataW-1:0] diff;
  logic [DataW-1:0]        mag, dabs;
  logic                    piv_zero, neg;
  logic [NumW-1:0]         num, quo;
  logic [DataW-1:0]        dvs, rem;
  logic [DataW:0]          rem_sh;
  logic                    qbit;
  logic [DataW-1:0]        qres;
  logic [IdxW-1:0]         sol_raddr;

  // stores
  always_ff @(posedge clk) begin
    if (cmd.wr_mat) mat_mem[{item.row, item.col}] <= item.value;
    if (cmd.rd_mac || cmd.rd_piv) mat_q <= mat_mem[{cmd.row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_rhs) rhs_mem[item.row] <= item.value;
    if (cmd.rd_piv) rhs_q <= rhs_mem[cmd.row];
  end

  assign sol_raddr = cmd.rd_out ? cmd.row : cmd.col;

  always_ff @(posedge clk) begin
    if (cmd.wr_sol) sol_mem[cmd.row] <= qres;
    if (cmd.rd_mac || cmd.rd_out) sol_q <= sol_mem[sol_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sol) zp_bits[cmd.row] <= piv_zero;
  end

  // multiply, round half up, accumulate
  assign rnd = (prod + ProdW'(64'sd1 <<< (FracBits - 1))) >>> FracBits;

  always_ff @(posedge clk) begin
    if (cmd.do_mul) prod <= $signed(mat_q) * $signed(sol_q);
    if (cmd.clr_sum) sum <= '0;
    else if (cmd.do_acc) sum <= sum + rnd;
  end

  // saturated difference and divider operands
  assign dfull = {{(ProdW-DataW){rhs_q[DataW-1]}}, rhs_q} - sum;

  always_comb begin
    if (dfull > ProdW'(64'sh7FFF_FFFF)) diff = 32'sh7FFF_FFFF;
    else if (dfull < -ProdW'(64'sh8000_0000)) diff = -32'sh7FFF_FFFF - 32'sd1;
    else diff = dfull[DataW-1:0];
    mag  = diff[DataW-1] ? DataW'(-diff) : diff;
    dabs = mat_q[DataW-1] ? DataW'(-$signed(mat_q)) : mat_q;
  end

  // restoring division step
  assign rem_sh = {rem, num[NumW-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.ld_piv) begin
      piv_zero <= (mat_q == '0);
      neg      <= diff[DataW-1] ^ mat_q[DataW-1];
      num      <= {mag, FracBits'(0)} + NumW'(dabs >> 1);
      dvs      <= dabs;
      rem      <= '0;
      quo      <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? DataW'(rem_sh - {1'b0, dvs}) : rem_sh[DataW-1:0];
      num <= {num[NumW-2:0], 1'b0};
      quo <= {quo[NumW-2:0], qbit};
    end
  end

  // signed, saturated quotient
  always_comb begin
    if (piv_zero) qres = '0;
    else if (neg) qres = (quo >= NumW'(64'h8000_0000)) ? 32'h8000_0000
                                                        : DataW'(-quo[DataW-1:0]);
    else qres = (quo > NumW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[DataW-1:0];
  end

  assign stat.piv_zero = piv_zero;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      result.index    <= cmd.row;
      result.solution <= sol_q;
      result.last     <= cmd.last;
      result.status   <= zp_bits[cmd.row];
    end
  end

endmodule
